[rtl/ucs_pkg.sv]
// shared types, constants and helpers of the url component splitter
package ucs_pkg;

    typedef enum logic [2:0] {
        PH_SCHEME  = 3'd0,
        PH_SLASH1  = 3'd1,
        PH_SLASH2  = 3'd2,
        PH_HOST    = 3'd3,
        PH_PORT    = 3'd4,
        PH_PATH    = 3'd5,
        PH_SWALLOW = 3'd6
    } ucs_phase_t;

    localparam logic [1:0] PART_SCHEME = 2'd0;
    localparam logic [1:0] PART_HOST   = 2'd1;
    localparam logic [1:0] PART_PATH   = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_CONTROL = 2'd1;
    localparam logic [1:0] ERR_SCHEME  = 2'd2;
    localparam logic [1:0] ERR_SLASHES = 2'd3;

    localparam int unsigned NUM_NAMES = 5;
    localparam int unsigned NAME_HTTPS = 1;

    // first character in the low byte
    localparam logic [39:0] NAME_STR [NUM_NAMES] = '{
        40'h00_70_74_74_68,
        40'h73_70_74_74_68,
        40'h00_00_00_73_77,
        40'h00_00_73_73_77,
        40'h00_00_70_74_66
    };
    localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{3'd4, 3'd5, 3'd2, 3'd3, 3'd3};
    localparam logic signed [16:0] NAME_PORT [NUM_NAMES] = '{
        17'sd80, 17'sd443, 17'sd80, 17'sd443, 17'sd21
    };

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // slot bits of a command, emitted lowest first
    localparam int unsigned SLOT_PRE  = 0;
    localparam int unsigned SLOT_BYTE = 1;
    localparam int unsigned SLOT_POST = 2;
    localparam int unsigned SLOT_DONE = 3;

    typedef struct packed {
        logic [3:0]         slots;
        logic [7:0]         data;
        logic [1:0]         part;
        logic signed [16:0] port;
        logic               secure;
        logic [1:0]         err;
    } ucs_cmd_t;

    function automatic logic [7:0] name_char(input int unsigned n, input logic [2:0] idx);
        logic [39:0] s;
        logic [7:0]  c;
        s = NAME_STR[n];
        c = 8'h00;
        if (idx < 3'd5)
        begin
            c = s[{idx, 3'b000} +: 8];
        end
        return c;
    endfunction

endpackage

[rtl/ucs_in_if.sv]
// input channel: raw url bytes with end-of-url flag
interface ucs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink (input valid, input in_byte, input last, output ready);
endinterface

[rtl/ucs_out_if.sv]
// output channel: component bytes and per-url summary
interface ucs_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         out_byte;
    logic [1:0]         part;
    logic               byte_valid;
    logic               done_res;
    logic signed [16:0] port_number;
    logic               https_flag;
    logic [1:0]         error_code;

    modport source (
        output valid, output out_byte, output part, output byte_valid,
        output done_res, output port_number, output https_flag, output error_code,
        input ready
    );
    modport sink (
        input valid, input out_byte, input part, input byte_valid,
        input done_res, input port_number, input https_flag, input error_code,
        output ready
    );
endinterface

[rtl/ucs_front.sv]
// front end: classifies each url byte, tracks parse state, builds commands
module ucs_front
    import ucs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ucs_in_if.sink     din,
    input  logic       q_full,
    output logic       push,
    output ucs_cmd_t   push_cmd
);

    ucs_phase_t  phase_reg, phase_next;
    logic [2:0]  count_reg, count_next;
    logic [4:0]  cand_reg, cand_next;
    logic [15:0] pval_reg, pval_next;
    logic        pneg_reg, pneg_next;
    logic        pseen_reg, pseen_next;
    logic        pstop_reg, pstop_next;
    logic        ctl_reg, ctl_next;
    logic [1:0]  perr_reg, perr_next;

    logic        acc;
    logic        fin;
    logic        is_sp;
    logic        is_ctl;
    logic [7:0]  b;
    logic [7:0]  lc;
    logic        emit_pre;
    logic        emit_byte;
    logic        emit_post;
    logic [7:0]  emit_data;
    logic [1:0]  emit_part;
    logic [19:0] pv_mul;
    logic [1:0]  perr_fin;
    logic [1:0]  err;
    logic [4:0]  matched;
    logic signed [16:0] def_port;
    logic signed [16:0] port_res;

    assign din.ready = !q_full;
    assign acc = din.valid && din.ready;
    assign fin = din.last;

    always_comb
    begin
        is_sp = (din.in_byte == CH_SPACE) || (din.in_byte == CH_TAB) ||
                (din.in_byte == CH_LF) || (din.in_byte == CH_VT) ||
                (din.in_byte == CH_FF) || (din.in_byte == CH_CR);
        is_ctl = !is_sp && (din.in_byte < CH_SPACE);
        b = (din.in_byte == CH_BSL) ? CH_SLASH : din.in_byte;
        lc = ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'h20) : b;
        pv_mul = {1'b0, pval_reg, 3'b000} + {3'b000, pval_reg, 1'b0} +
                 {16'h0000, b[3:0] & 4'hF};
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        cand_next  = cand_reg;
        pval_next  = pval_reg;
        pneg_next  = pneg_reg;
        pseen_next = pseen_reg;
        pstop_next = pstop_reg;
        ctl_next   = ctl_reg;
        perr_next  = perr_reg;
        emit_pre   = 1'b0;
        emit_byte  = 1'b0;
        emit_data  = b;
        emit_part  = PART_PATH;
        if (is_ctl)
        begin
            ctl_next = 1'b1;
        end
        else if (!is_sp)
        begin
            case (phase_reg)
                PH_SCHEME:
                begin
                    if (b == CH_COLON)
                    begin
                        if (count_reg == 3'd0)
                        begin
                            perr_next  = ERR_SCHEME;
                            phase_next = PH_SWALLOW;
                        end
                        else
                        begin
                            phase_next = PH_SLASH1;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_NAMES; i++)
                        begin
                            if ((count_reg >= NAME_LEN[i]) || (name_char(i, count_reg) != lc))
                            begin
                                cand_next[i] = 1'b0;
                            end
                        end
                        if (count_reg != 3'd7)
                        begin
                            count_next = count_reg + 3'd1;
                        end
                        emit_byte = 1'b1;
                        emit_data = lc;
                        emit_part = PART_SCHEME;
                    end
                end
                PH_SLASH1, PH_SLASH2:
                begin
                    if (b == CH_SLASH)
                    begin
                        phase_next = (phase_reg == PH_SLASH1) ? PH_SLASH2 : PH_HOST;
                    end
                    else
                    begin
                        perr_next  = ERR_SLASHES;
                        phase_next = PH_SWALLOW;
                    end
                end
                PH_HOST, PH_PORT:
                begin
                    if ((b == CH_SLASH) || (b == CH_QUEST) || (b == CH_HASH))
                    begin
                        emit_pre   = (b != CH_SLASH);
                        emit_byte  = 1'b1;
                        phase_next = PH_PATH;
                    end
                    else if ((phase_reg == PH_HOST) && (b == CH_COLON))
                    begin
                        phase_next = PH_PORT;
                    end
                    else if (phase_reg == PH_HOST)
                    begin
                        emit_byte = 1'b1;
                        emit_part = PART_HOST;
                    end
                    else
                    begin
                        pseen_next = 1'b1;
                        if (!pstop_reg)
                        begin
                            if ((b >= 8'h30) && (b <= 8'h39))
                            begin
                                pval_next = (pv_mul > 20'd65535) ? 16'hFFFF : pv_mul[15:0];
                            end
                            else if (!pseen_reg && (b == CH_PLUS))
                            begin
                                pstop_next = 1'b0;
                            end
                            else if (!pseen_reg && (b == CH_MINUS))
                            begin
                                pneg_next = 1'b1;
                            end
                            else
                            begin
                                pstop_next = 1'b1;
                            end
                        end
                    end
                end
                PH_PATH:
                begin
                    emit_byte = 1'b1;
                end
                default:
                begin
                    emit_byte = 1'b0;
                end
            endcase
        end
    end

    // end-of-url summary from the updated state
    always_comb
    begin
        perr_fin  = perr_next;
        emit_post = 1'b0;
        if ((phase_next == PH_SCHEME) && (perr_next == ERR_NONE))
        begin
            perr_fin = ERR_SCHEME;
        end
        else if (((phase_next == PH_SLASH1) || (phase_next == PH_SLASH2)) &&
                 (perr_next == ERR_NONE))
        begin
            perr_fin = ERR_SLASHES;
        end
        else if ((phase_next == PH_HOST) || (phase_next == PH_PORT))
        begin
            emit_post = 1'b1;
        end
        err = ctl_next ? ERR_CONTROL : perr_fin;
        for (int i = 0; i < NUM_NAMES; i++)
        begin
            matched[i] = cand_next[i] && (count_next == NAME_LEN[i]);
        end
        def_port = -17'sd1;
        for (int i = NUM_NAMES - 1; i >= 0; i--)
        begin
            if (matched[i])
            begin
                def_port = NAME_PORT[i];
            end
        end
        if (pseen_next)
        begin
            port_res = pneg_next ? (17'sd0 - $signed({1'b0, pval_next}))
                                 : $signed({1'b0, pval_next});
        end
        else
        begin
            port_res = def_port;
        end
    end

    always_comb
    begin
        push_cmd.slots[SLOT_PRE]  = emit_pre;
        push_cmd.slots[SLOT_BYTE] = emit_byte;
        push_cmd.slots[SLOT_POST] = fin && emit_post;
        push_cmd.slots[SLOT_DONE] = fin;
        push_cmd.data   = emit_data;
        push_cmd.part   = emit_part;
        push_cmd.port   = (err == ERR_NONE) ? port_res : 17'sd0;
        push_cmd.secure = (err == ERR_NONE) && matched[NAME_HTTPS];
        push_cmd.err    = err;
        push = acc && (push_cmd.slots != 4'b0000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SCHEME;
            count_reg <= 3'd0;
            cand_reg  <= 5'h1F;
            pval_reg  <= 16'h0000;
            pneg_reg  <= 1'b0;
            pseen_reg <= 1'b0;
            pstop_reg <= 1'b0;
            ctl_reg   <= 1'b0;
            perr_reg  <= ERR_NONE;
        end
        else if (acc && fin)
        begin
            phase_reg <= PH_SCHEME;
            count_reg <= 3'd0;
            cand_reg  <= 5'h1F;
            pval_reg  <= 16'h0000;
            pneg_reg  <= 1'b0;
            pseen_reg <= 1'b0;
            pstop_reg <= 1'b0;
            ctl_reg   <= 1'b0;
            perr_reg  <= ERR_NONE;
        end
        else if (acc)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            cand_reg  <= cand_next;
            pval_reg  <= pval_next;
            pneg_reg  <= pneg_next;
            pseen_reg <= pseen_next;
            pstop_reg <= pstop_next;
            ctl_reg   <= ctl_next;
            perr_reg  <= perr_next;
        end
    end

endmodule

[rtl/ucs_queue.sv]
// command queue between front and back end
module ucs_queue
    import ucs_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ucs_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output ucs_cmd_t pop_cmd,
    output logic     empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ucs_cmd_t        entry_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == CW'(0));
    assign pop_cmd = entry_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/ucs_back.sv]
// back end: expands each command into one to three output words
module ucs_back
    import ucs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ucs_cmd_t pop_cmd,
    input  logic     empty,
    output logic     pop,
    ucs_out_if.source dout
);

    ucs_cmd_t   cmd_reg, cmd_next;
    logic [3:0] mask_reg, mask_next;
    logic [3:0] sel;
    logic [3:0] rem;
    logic       fire;

    always_comb
    begin
        sel  = mask_reg & (~mask_reg + 4'd1);
        fire = dout.valid && dout.ready;
        rem  = fire ? (mask_reg & ~sel) : mask_reg;
        pop  = (rem == 4'b0000) && !empty;
        cmd_next  = pop ? pop_cmd : cmd_reg;
        mask_next = pop ? pop_cmd.slots : rem;
    end

    always_comb
    begin
        dout.valid       = (mask_reg != 4'b0000);
        dout.done_res    = sel[SLOT_DONE];
        dout.byte_valid  = !sel[SLOT_DONE];
        dout.port_number = sel[SLOT_DONE] ? cmd_reg.port : 17'sd0;
        dout.https_flag  = sel[SLOT_DONE] && cmd_reg.secure;
        dout.error_code  = sel[SLOT_DONE] ? cmd_reg.err : ERR_NONE;
        if (sel[SLOT_DONE])
        begin
            dout.out_byte = 8'h00;
            dout.part     = PART_SCHEME;
        end
        else if (sel[SLOT_BYTE])
        begin
            dout.out_byte = cmd_reg.data;
            dout.part     = cmd_reg.part;
        end
        else
        begin
            dout.out_byte = CH_SLASH;
            dout.part     = PART_PATH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 4'b0000;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

[rtl/url_component_splitter.sv]
// top level of the streaming url component splitter
//
// din takes one raw url byte per word, with last on the final byte of a url.
// dout gives the scheme (lowercased), hostname and path bytes tagged by
// part, then one summary word with done_res set carrying port, https flag
// and error code. Whitespace is dropped, backslash becomes '/'.
// Throughput: one input word per cycle while the queue is not full.
// A byte yields at most one output word except at a delimiter or at the end
// of a url, where up to three words follow from one input word.
// A byte's command passes the queue entry and the back-end command register.
// The front end updates parse state and pushes a command into
// a queue of QUEUE_DEPTH entries; the back end drains it at the output rate.
// When dout stalls the queue fills and din.ready drops; nothing is lost.
// Reset clears the parse state and empties the queue; the next byte
// starts a new url.
module url_component_splitter
    import ucs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    ucs_in_if.sink    din,
    ucs_out_if.source dout
);

    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;
    ucs_cmd_t push_cmd;
    ucs_cmd_t pop_cmd;

    ucs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .din      (din),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ucs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    ucs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .pop_cmd (pop_cmd),
        .empty   (q_empty),
        .pop     (pop),
        .dout    (dout)
    );

`ifndef SYNTHESIS
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (dout.byte_valid != dout.done_res))
        else $error("output word must be either a byte or a summary");

    a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.done_res && (dout.error_code != ERR_NONE)) |->
        ((dout.port_number == 17'sd0) && !dout.https_flag))
        else $error("summary with error carries port or https flag");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("queue popped while empty");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && q_full && !pop) |=> 1'b0)
        else $error("queue pushed while full");
`endif

endmodule

[dv/url_component_splitter_test.sv]
// testbench of the url component splitter: directed and random urls checked word by word
`timescale 1ns / 1ps

module url_component_splitter_test;
    import ucs_pkg::*;

    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 75;

    typedef struct packed {
        logic [7:0]         data;
        logic [1:0]         part;
        logic               bv;
        logic               done;
        logic signed [16:0] port;
        logic               secure;
        logic [1:0]         err;
    } url_word_t;

    class url_part_tracker;
        string      names[NUM_NAMES] = '{"http", "https", "ws", "wss", "ftp"};
        int         name_ports[NUM_NAMES] = '{80, 443, 80, 443, 21};
        ucs_phase_t phase;
        logic [2:0] scheme_len;
        logic [4:0] name_hits;
        int         port_val;
        bit         port_neg;
        bit         port_seen;
        bit         port_stop;
        bit         ctrl_err;
        logic [1:0] parse_err;
        url_word_t  expected_words[$];
        int         errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase      = PH_SCHEME;
            scheme_len = 3'd0;
            name_hits  = 5'h1F;
            port_val   = 0;
            port_neg   = 0;
            port_seen  = 0;
            port_stop  = 0;
            ctrl_err   = 0;
            parse_err  = ERR_NONE;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void emit(logic [7:0] b, logic [1:0] part);
            url_word_t w;
            w = '0;
            w.data = b;
            w.part = part;
            w.bv   = 1'b1;
            expected_words.push_back(w);
        endfunction

        function bit name_full(int i);
            return name_hits[i] && (scheme_len == names[i].len());
        endfunction

        function void read_port(logic [7:0] b);
            bit first;
            first = !port_seen;
            port_seen = 1;
            if (!port_stop)
            begin
                if (b >= "0" && b <= "9")
                begin
                    port_val = port_val * 10 + int'(b - "0");
                    if (port_val > 65535)
                        port_val = 65535;
                end
                else if (first && b == CH_PLUS)
                begin
                end
                else if (first && b == CH_MINUS)
                    port_neg = 1;
                else
                    port_stop = 1;
            end
        endfunction

        function void take_byte(logic [7:0] b_in, logic fin);
            logic [7:0] b;
            logic [7:0] lc;
            url_word_t  w;
            int         p;
            bit         found;
            b = b_in;
            if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF
                || b == CH_CR)
            begin
            end
            else if (b < CH_SPACE)
                ctrl_err = 1;
            else
            begin
                if (b == CH_BSL)
                    b = CH_SLASH;
                case (phase)
                    PH_SCHEME:
                    begin
                        if (b == CH_COLON)
                        begin
                            if (scheme_len == 3'd0)
                            begin
                                parse_err = ERR_SCHEME;
                                phase = PH_SWALLOW;
                            end
                            else
                                phase = PH_SLASH1;
                        end
                        else
                        begin
                            lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                            for (int i = 0; i < NUM_NAMES; i++)
                            begin
                                if (scheme_len >= names[i].len() || names[i][scheme_len] != lc)
                                    name_hits[i] = 1'b0;
                            end
                            if (scheme_len != 3'd7)
                                scheme_len++;
                            emit(lc, PART_SCHEME);
                        end
                    end
                    PH_SLASH1, PH_SLASH2:
                    begin
                        if (b != CH_SLASH)
                        begin
                            parse_err = ERR_SLASHES;
                            phase = PH_SWALLOW;
                        end
                        else if (phase == PH_SLASH1)
                            phase = PH_SLASH2;
                        else
                            phase = PH_HOST;
                    end
                    PH_HOST, PH_PORT:
                    begin
                        if (b == CH_SLASH || b == CH_QUEST || b == CH_HASH)
                        begin
                            if (b != CH_SLASH)
                                emit(CH_SLASH, PART_PATH);
                            emit(b, PART_PATH);
                            phase = PH_PATH;
                        end
                        else if (phase == PH_HOST && b == CH_COLON)
                            phase = PH_PORT;
                        else if (phase == PH_HOST)
                            emit(b, PART_HOST);
                        else
                            read_port(b);
                    end
                    PH_PATH:
                        emit(b, PART_PATH);
                    default:
                    begin
                    end
                endcase
            end

            if (fin)
            begin
                if (phase == PH_SCHEME && parse_err == ERR_NONE)
                    parse_err = ERR_SCHEME;
                else if ((phase == PH_SLASH1 || phase == PH_SLASH2) && parse_err == ERR_NONE)
                    parse_err = ERR_SLASHES;
                else if (phase == PH_HOST || phase == PH_PORT)
                    emit(CH_SLASH, PART_PATH);
                w = '0;
                w.done = 1'b1;
                w.err = ctrl_err ? ERR_CONTROL : parse_err;
                if (w.err == ERR_NONE)
                begin
                    if (port_seen)
                        p = port_neg ? -port_val : port_val;
                    else
                    begin
                        p = -1;
                        found = 0;
                        for (int i = 0; i < NUM_NAMES; i++)
                        begin
                            if (!found && name_full(i))
                            begin
                                p = name_ports[i];
                                found = 1;
                            end
                        end
                    end
                    w.port = p[16:0];
                    w.secure = name_full(NAME_HTTPS);
                end
                expected_words.push_back(w);
                clear_state();
            end
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_word(url_word_t got);
            url_word_t want;
            if (expected_words.size() == 0)
            begin
                $error("word with none expected: out_byte %0d part %0d done_res %0d",
                       got.data, got.part, got.done);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("out_byte", want.data, got.data);
            compare_field("part", want.part, got.part);
            compare_field("byte_valid", want.bv, got.bv);
            compare_field("done_res", want.done, got.done);
            compare_field("port_number", $signed(want.port), $signed(got.port));
            compare_field("https_flag", want.secure, got.secure);
            compare_field("error_code", want.err, got.err);
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    bit              quiet = 0;
    bit              holding = 0;
    bit              hold_req = 0;
    int              bytes_sent = 0;
    logic [7:0]      url_bytes[$];
    url_part_tracker tracker;

    ucs_in_if  din ();
    ucs_out_if dout ();

    url_component_splitter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] pick_char(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void add(string s);
        for (int k = 0; k < s.len(); k++)
            url_bytes.push_back(s[k]);
    endfunction

    task automatic send_byte(logic [7:0] b, logic fin);
        int gap;
        @(negedge clk);
        if (!quiet && !holding && $urandom_range(0, 5) == 0)
        begin
            din.valid = 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(negedge clk);
        end
        din.valid = 1'b1;
        din.in_byte = b;
        din.last = fin;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
        tracker.take_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_url();
        for (int k = 0; k < url_bytes.size(); k++)
            send_byte(url_bytes[k], k == url_bytes.size() - 1);
        url_bytes.delete();
    endtask

    task automatic gen_url();
        int         n;
        int         pick;
        logic [7:0] c;
        if ($urandom_range(0, 11) == 0)
        begin
            n = $urandom_range(1, 8);
            repeat (n) url_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, NUM_NAMES - 1);
                for (int k = 0; k < tracker.names[pick].len(); k++)
                begin
                    c = tracker.names[pick][k];
                    if ($urandom_range(0, 2) == 0)
                        c = c - 8'd32;
                    url_bytes.push_back(c);
                end
            end
            else
            begin
                n = $urandom_range(0, 8);
                repeat (n) url_bytes.push_back(pick_char("hTtPsWfxyz+-.9"));
            end

            case ($urandom_range(0, 9))
                0: add(":");
                1: add(":/");
                2:
                begin
                end
                default:
                begin
                    add(":");
                    repeat (2) url_bytes.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSL);
                end
            endcase

            n = $urandom_range(0, 6);
            repeat (n) url_bytes.push_back(pick_char("abcxyz.-_~%AZ09@"));

            if ($urandom_range(0, 2) == 0)
            begin
                add(":");
                case ($urandom_range(0, 3))
                    0: add("+");
                    1: add("-");
                    default:
                    begin
                    end
                endcase
                n = $urandom_range(0, 7);
                repeat (n) url_bytes.push_back(pick_char("0123456789"));
                if ($urandom_range(0, 3) == 0)
                    url_bytes.push_back(pick_char("x:+-5"));
            end

            case ($urandom_range(0, 4))
                0:
                begin
                end
                1: url_bytes.push_back(CH_SLASH);
                2: url_bytes.push_back(CH_QUEST);
                3: url_bytes.push_back(CH_HASH);
                default: url_bytes.push_back(CH_BSL);
            endcase
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                if ($urandom_range(0, 7) == 0)
                    url_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
                else
                    url_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end

            if ($urandom_range(0, 4) == 0)
                url_bytes.insert($urandom_range(0, url_bytes.size()),
                                 pick_char(" \t\n\v\f\r"));
            if ($urandom_range(0, 19) == 0)
                url_bytes.insert($urandom_range(0, url_bytes.size()),
                                 8'($urandom_range(0, 8'h1F)));
        end
        if (url_bytes.size() == 0)
            url_bytes.push_back(CH_SPACE);
        send_url();
    endtask

    // output side: random stalls plus one long hold-off
    initial
    begin
        int stall;
        stall = 0;
        dout.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                holding = 1;
                dout.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holding = 0;
            end
            if (stall > 0)
            begin
                dout.ready = 1'b0;
                stall--;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                dout.ready = 1'b0;
                stall = $urandom_range(1, 17) - 1;
            end
            else
                dout.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        url_word_t seen;
        if (rst_n && dout.valid && dout.ready)
        begin
            seen.data   = dout.out_byte;
            seen.part   = dout.part;
            seen.bv     = dout.byte_valid;
            seen.done   = dout.done_res;
            seen.port   = dout.port_number;
            seen.secure = dout.https_flag;
            seen.err    = dout.error_code;
            tracker.check_word(seen);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((din.valid && din.ready) || (dout.valid && dout.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("url_component_splitter test failed");
        $finish;
    end

    initial
    begin
        din.valid = 1'b0;
        din.in_byte = 8'h00;
        din.last = 1'b0;
        rst_n = 1'b0;
        tracker = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // colon before any scheme byte
        add(":x");
        send_url();
        // url ends inside the scheme
        add("a");
        send_url();
        // control byte wins over missing slashes
        add("f:");
        url_bytes.push_back(8'h00);
        add("x");
        send_url();
        // whitespace only
        add(" ");
        send_url();
        // backslashes, negative port, path opened by '#'
        add("H:\\/h:-9#");
        url_bytes.push_back(8'hFF);
        send_url();
        // default port, url ends in the hostname
        add("wsS://x");
        send_url();

        hold_req = 1;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent >= RANDOM_BYTES - 30)
                quiet = 1;
            gen_url();
        end
        @(negedge clk);
        din.valid = 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("url_component_splitter test passed");
        else
            $display("url_component_splitter test failed");
        $finish;
    end

endmodule
